// ===== hw/rtl/wpm_pkg.sv =====
// ----------------------------------------------------------------------------
// wpm_pkg
// shared constants, codes and types of the wildcard pattern matcher
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int ROW_W       = PATTERN_MAX + 1;
    localparam int LEN_W       = 6;
    localparam int CHAR_W      = 8;
    localparam int WORD_W      = 64;
    localparam int PAT_W       = PATTERN_MAX * CHAR_W;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_D = 3'd4;

    // input kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_RIPPLE
    } t_state;

    // per-cycle command to the cell row
    typedef struct packed {
        logic load_start;
        logic load_byte;
        logic ripple;
    } t_cell_ctrl;

endpackage

// ===== hw/rtl/wildcard_pattern_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_unit
// streamed glob matcher ('?' any byte, '*' any run) over a row of match cells
// ----------------------------------------------------------------------------
//
//  channel   valid        ready        payload
//  -------   ----------   ----------   -------------------------------
//  input     i_valid      o_ready      i_kind, i_text_char
//  output    o_valid      i_ready      o_matched
//  config    i_cfg_valid  o_cfg_ready  i_cfg_index, i_cfg_data
//
//  on acceptance the row loads the new match bits, which then travel
//  through the runs of star cells until the row settles: the star ripple
//  moves one cell per cycle down the cell row
//  the request is accepted only while the row is idle; the result sits in an
//  output register, so the next request is taken while it waits
//  a stalled output holds the row in the ripple state with its bits settled
//  synchronous active-low reset clears the row, the registers and the result valid flag
//
module wildcard_pattern_matcher_unit
    import wpm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input requests
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic [CHAR_W-1:0]    i_text_char,
    // results
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_matched,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    // configuration registers
    logic [LEN_W-1:0]  r_len;
    logic [WORD_W-1:0] r_pat_a;
    logic [WORD_W-1:0] r_pat_b;
    logic [WORD_W-1:0] r_pat_c;
    logic [WORD_W-1:0] r_pat_d;
    logic [PAT_W-1:0]  w_pat;

    // control
    t_state     r_state;
    t_state     n_state;
    t_cell_ctrl w_ctrl;
    logic       w_in_accept;
    logic       w_done;

    // row and result
    logic [ROW_W-1:0] w_row;
    logic             w_any_change;
    logic [LEN_W-1:0] w_sel;
    logic             r_out_valid;
    logic             r_matched;

    // ------------------------------------------------------------------
    // register writes, always accepted; unknown indexes are dropped
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_pat_a <= '0;
            r_pat_b <= '0;
            r_pat_c <= '0;
            r_pat_d <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LENGTH:  r_len   <= i_cfg_data[LEN_W-1:0];
                CFG_CHARS_A: r_pat_a <= i_cfg_data;
                CFG_CHARS_B: r_pat_b <= i_cfg_data;
                CFG_CHARS_C: r_pat_c <= i_cfg_data;
                CFG_CHARS_D: r_pat_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // character 0 is the lowest byte of word a
    assign w_pat = {r_pat_d, r_pat_c, r_pat_b, r_pat_a};

    // ------------------------------------------------------------------
    // sequencer: load the row on acceptance, then ripple until settled
    // ------------------------------------------------------------------
    assign w_in_accept = i_valid & o_ready;

    // settled row and a free (or freeing) result slot
    assign w_done = (r_state == ST_RIPPLE) && !w_any_change && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RIPPLE;
                end
            end
            ST_RIPPLE: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready           = 1'b0;
        w_ctrl.load_start = 1'b0;
        w_ctrl.load_byte  = 1'b0;
        w_ctrl.ripple     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready           = 1'b1;
                // the row takes the base bits straight from the request
                w_ctrl.load_start = i_valid && (i_kind == KIND_START);
                w_ctrl.load_byte  = i_valid && (i_kind == KIND_BYTE);
            end
            ST_RIPPLE: begin
                w_ctrl.ripple = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------
    wpm_row u_row (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_pat        (w_pat),
        .i_text_char  (i_text_char),
        .o_row        (w_row),
        .o_any_change (w_any_change)
    );

    // ------------------------------------------------------------------
    // result: bit at the pattern length, saturated to the row's last bit
    // ------------------------------------------------------------------
    assign w_sel = (r_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_matched <= w_row[w_sel];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_matched = r_matched;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // an accepted request always starts a ripple pass
    a_accept_to_ripple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == ST_RIPPLE))
        else $error("accepted request did not enter ripple");

    // a start request sets the empty-prefix bit
    a_start_sets_bit0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_kind == KIND_START)) |=> w_row[0])
        else $error("start request left bit 0 clear");

    // a text byte never matches the empty prefix
    a_byte_clears_bit0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_kind == KIND_BYTE)) |=> !w_row[0])
        else $error("text byte left bit 0 set");

    // a new result only comes out of a settled ripple pass
    a_result_from_ripple: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> $past(r_state == ST_RIPPLE && !w_any_change))
        else $error("result produced outside a settled ripple pass");

endmodule

// ===== hw/rtl/wpm_cell.sv =====
// ----------------------------------------------------------------------------
// wpm_cell
// one match bit of the row, for one pattern prefix
// ----------------------------------------------------------------------------
module wpm_cell
    import wpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [CHAR_W-1:0] i_pat_char,
    input  logic [CHAR_W-1:0] i_text_char,
    input  logic              i_left_bit,
    output logic              o_bit,
    output logic              o_changed
);

    logic r_bit;
    logic n_bit;
    logic w_star;
    logic w_hit;

    assign w_star = (i_pat_char == STAR_CHAR);

    always_comb begin
        if (w_star) begin
            w_hit = r_bit;
        end else if ((i_pat_char == ANY_CHAR) || (i_pat_char == i_text_char)) begin
            w_hit = i_left_bit;
        end else begin
            w_hit = 1'b0;
        end
    end

    // a star cell picks up its left neighbor's bit
    assign o_changed = w_star & i_left_bit & ~r_bit;

    always_comb begin
        if (i_ctrl.load_start) begin
            n_bit = 1'b0;
        end else if (i_ctrl.load_byte) begin
            n_bit = w_hit;
        end else if (i_ctrl.ripple) begin
            n_bit = r_bit | (w_star & i_left_bit);
        end else begin
            n_bit = r_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

// ===== hw/rtl/wpm_row.sv =====
// ----------------------------------------------------------------------------
// wpm_row
// row of match cells, bit 0 for the empty pattern prefix
// ----------------------------------------------------------------------------
module wpm_row
    import wpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [PAT_W-1:0]  i_pat,
    input  logic [CHAR_W-1:0] i_text_char,
    output logic [ROW_W-1:0]  o_row,
    output logic              o_any_change
);

    logic                   r_bit0;
    logic [PATTERN_MAX-1:0] w_changed;

    // empty prefix matches only the empty text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit0 <= 1'b0;
        end else if (i_ctrl.load_start) begin
            r_bit0 <= 1'b1;
        end else if (i_ctrl.load_byte) begin
            r_bit0 <= 1'b0;
        end
    end

    assign o_row[0] = r_bit0;

    for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
        wpm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (i_ctrl),
            .i_pat_char  (i_pat[(j-1)*CHAR_W +: CHAR_W]),
            .i_text_char (i_text_char),
            .i_left_bit  (o_row[j-1]),
            .o_bit       (o_row[j]),
            .o_changed   (w_changed[j-1])
        );
    end

    assign o_any_change = |w_changed;

endmodule
